>>> hdl/qau_pkg.sv
// qau_pkg: shared constants, types and helpers of the quaternion arithmetic unit
// used by every module of the unit; depends on nothing
`default_nettype none

package qau_pkg;

	localparam int DATA_W    = 32;
	localparam int FRAC_BITS = 16;
	localparam int PROD_W    = 2 * DATA_W;
	localparam int ACC_W     = PROD_W + 3;

	localparam int N_Q   = 4;
	localparam int N_M   = 9;
	localparam int N_SUM = N_Q + N_M;
	localparam int N_V   = 3;

	typedef enum logic [1:0] {
		MODE_QMUL = 2'd0,
		MODE_ROT  = 2'd1,
		MODE_RATE = 2'd2,
		MODE_NONE = 2'd3
	} mode_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] val;
		logic                     sat;
	} rnd_t;

	function automatic logic signed [ACC_W-1:0] sext_p(input logic signed [PROD_W-1:0] p);
		return {{(ACC_W-PROD_W){p[PROD_W-1]}}, p};
	endfunction

endpackage

`default_nettype wire

>>> hdl/qau_round_lane.sv
// qau_round_lane: one lane of round half up, shift and clip to 32 bits, registered
// depends on qau_pkg
`default_nettype none

module qau_round_lane (
	input  wire logic                            clk,
	input  wire logic signed [qau_pkg::ACC_W-1:0] acc,
	output qau_pkg::rnd_t                         res
);

	localparam logic signed [qau_pkg::ACC_W-1:0] HALF =
		qau_pkg::ACC_W'(1) <<< (qau_pkg::FRAC_BITS - 1);
	localparam int HI_LO = qau_pkg::FRAC_BITS + qau_pkg::DATA_W - 1;

	logic signed [qau_pkg::ACC_W-1:0] t;
	logic [qau_pkg::ACC_W-1-HI_LO:0]  hi;
	logic                             fits;
	qau_pkg::rnd_t                    nxt;
	qau_pkg::rnd_t                    res_q;

	always_comb begin
		t    = acc + HALF;
		hi   = t[qau_pkg::ACC_W-1:HI_LO];
		fits = (&hi) | ~(|hi);
		if (fits) begin
			nxt.val = t[HI_LO:qau_pkg::FRAC_BITS];
			nxt.sat = 1'b0;
		end else begin
			nxt.val = t[qau_pkg::ACC_W-1] ? {1'b1, {(qau_pkg::DATA_W-1){1'b0}}}
				: {1'b0, {(qau_pkg::DATA_W-1){1'b1}}};
			nxt.sat = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		res_q <= nxt;
	end

	assign res = res_q;

endmodule

`default_nettype wire

>>> hdl/qau_quat_stage.sv
// qau_quat_stage: operand products (stage 1) and sums of products (stage 2)
// gives the four quaternion sums and the nine rotation matrix sums; depends on qau_pkg
`default_nettype none

module qau_quat_stage (
	input  wire logic                             clk,
	input  wire qau_pkg::mode_t                   mode_s1,
	input  wire logic signed [qau_pkg::DATA_W-1:0] a_x,
	input  wire logic signed [qau_pkg::DATA_W-1:0] a_y,
	input  wire logic signed [qau_pkg::DATA_W-1:0] a_z,
	input  wire logic signed [qau_pkg::DATA_W-1:0] a_w,
	input  wire logic signed [qau_pkg::DATA_W-1:0] b_x,
	input  wire logic signed [qau_pkg::DATA_W-1:0] b_y,
	input  wire logic signed [qau_pkg::DATA_W-1:0] b_z,
	input  wire logic signed [qau_pkg::DATA_W-1:0] b_w,
	output logic signed [qau_pkg::ACC_W-1:0]       sum_s2 [qau_pkg::N_SUM]
);

	localparam logic signed [qau_pkg::ACC_W-1:0] ONE_ACC =
		qau_pkg::ACC_W'(1) <<< (2 * qau_pkg::FRAC_BITS);

	logic signed [qau_pkg::DATA_W-1:0] av [4];
	logic signed [qau_pkg::DATA_W-1:0] bv [4];
	logic signed [qau_pkg::PROD_W-1:0] p_s1 [4][4];
	logic signed [qau_pkg::PROD_W-1:0] pxx_s1, pyy_s1, pzz_s1;
	logic signed [qau_pkg::PROD_W-1:0] pxy_s1, pxz_s1, pyz_s1;
	logic signed [qau_pkg::PROD_W-1:0] pxw_s1, pyw_s1, pzw_s1;
	logic signed [qau_pkg::ACC_W-1:0]  e [4][4];
	logic signed [qau_pkg::ACC_W-1:0]  xx2, yy2, zz2, xy2, xz2, yz2, xw2, yw2, zw2;
	logic signed [qau_pkg::ACC_W-1:0]  nsum [qau_pkg::N_SUM];

	assign av = '{a_x, a_y, a_z, a_w};
	assign bv = '{b_x, b_y, b_z, b_w};

	always_ff @(posedge clk) begin
		for (int i = 0; i < 4; i++) begin
			for (int j = 0; j < 4; j++) begin
				p_s1[i][j] <= bv[i] * av[j];
			end
		end
		pxx_s1 <= a_x * a_x;
		pyy_s1 <= a_y * a_y;
		pzz_s1 <= a_z * a_z;
		pxy_s1 <= a_x * a_y;
		pxz_s1 <= a_x * a_z;
		pyz_s1 <= a_y * a_z;
		pxw_s1 <= a_x * a_w;
		pyw_s1 <= a_y * a_w;
		pzw_s1 <= a_z * a_w;
	end

	// e[i][j] is b_i * a_j, index order x y z w
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			for (int j = 0; j < 4; j++) begin
				e[i][j] = qau_pkg::sext_p(p_s1[i][j]);
			end
		end
		xx2 = qau_pkg::sext_p(pxx_s1) <<< 1;
		yy2 = qau_pkg::sext_p(pyy_s1) <<< 1;
		zz2 = qau_pkg::sext_p(pzz_s1) <<< 1;
		xy2 = qau_pkg::sext_p(pxy_s1) <<< 1;
		xz2 = qau_pkg::sext_p(pxz_s1) <<< 1;
		yz2 = qau_pkg::sext_p(pyz_s1) <<< 1;
		xw2 = qau_pkg::sext_p(pxw_s1) <<< 1;
		yw2 = qau_pkg::sext_p(pyw_s1) <<< 1;
		zw2 = qau_pkg::sext_p(pzw_s1) <<< 1;

		unique case (mode_s1)
			qau_pkg::MODE_QMUL: begin
				nsum[0] = e[3][0] + e[0][3] + e[1][2] - e[2][1];
				nsum[1] = e[3][1] - e[0][2] + e[1][3] + e[2][0];
				nsum[2] = e[3][2] + e[0][1] - e[1][0] + e[2][3];
				nsum[3] = e[3][3] - e[0][0] - e[1][1] - e[2][2];
			end
			qau_pkg::MODE_RATE: begin
				nsum[0] = e[2][1] - e[1][2] + e[0][3];
				nsum[1] = e[0][2] - e[2][0] + e[1][3];
				nsum[2] = e[1][0] - e[0][1] + e[2][3];
				nsum[3] = -e[0][0] - e[1][1] - e[2][2];
			end
			qau_pkg::MODE_ROT, qau_pkg::MODE_NONE: begin
				for (int k = 0; k < qau_pkg::N_Q; k++) begin
					nsum[k] = '0;
				end
			end
		endcase

		// rotation matrix, row major
		nsum[qau_pkg::N_Q + 0] = ONE_ACC - yy2 - zz2;
		nsum[qau_pkg::N_Q + 1] = xy2 - zw2;
		nsum[qau_pkg::N_Q + 2] = xz2 + yw2;
		nsum[qau_pkg::N_Q + 3] = xy2 + zw2;
		nsum[qau_pkg::N_Q + 4] = ONE_ACC - xx2 - zz2;
		nsum[qau_pkg::N_Q + 5] = yz2 - xw2;
		nsum[qau_pkg::N_Q + 6] = xz2 - yw2;
		nsum[qau_pkg::N_Q + 7] = yz2 + xw2;
		nsum[qau_pkg::N_Q + 8] = ONE_ACC - xx2 - yy2;
	end

	always_ff @(posedge clk) begin
		sum_s2 <= nsum;
	end

endmodule

`default_nettype wire

>>> hdl/qau_rot_stage.sv
// qau_rot_stage: matrix times vector products (stage 4) and row sums (stage 5)
// depends on qau_pkg
`default_nettype none

module qau_rot_stage (
	input  wire logic                             clk,
	input  wire logic signed [qau_pkg::DATA_W-1:0] mat [qau_pkg::N_M],
	input  wire logic signed [qau_pkg::DATA_W-1:0] vec [qau_pkg::N_V],
	output logic signed [qau_pkg::ACC_W-1:0]       rsum_s5 [qau_pkg::N_V]
);

	logic signed [qau_pkg::PROD_W-1:0] mv_s4 [qau_pkg::N_M];
	logic signed [qau_pkg::ACC_W-1:0]  nsum [qau_pkg::N_V];

	always_ff @(posedge clk) begin
		for (int r = 0; r < qau_pkg::N_V; r++) begin
			for (int c = 0; c < qau_pkg::N_V; c++) begin
				mv_s4[r*qau_pkg::N_V + c] <= mat[r*qau_pkg::N_V + c] * vec[c];
			end
		end
	end

	always_comb begin
		for (int r = 0; r < qau_pkg::N_V; r++) begin
			nsum[r] = qau_pkg::sext_p(mv_s4[r*qau_pkg::N_V])
				+ qau_pkg::sext_p(mv_s4[r*qau_pkg::N_V + 1])
				+ qau_pkg::sext_p(mv_s4[r*qau_pkg::N_V + 2]);
		end
	end

	always_ff @(posedge clk) begin
		rsum_s5 <= nsum;
	end

endmodule

`default_nettype wire

>>> hdl/quaternion_arith_unit.sv
// quaternion_arith_unit: top level of the fixed-point quaternion unit
// depends on qau_pkg, qau_quat_stage, qau_round_lane, qau_rot_stage
//
// channel  | handshake        | payload
// ---------+------------------+------------------------------------------
// command  | start, busy      | mode, a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w
// result   | done (one cycle) | r_x, r_y, r_z, r_w, saturated
//
// six-stage pipeline: products, sums, round, matrix products, row sums, round
// one beat accepted every cycle; each result passes through every stage in order before done
// busy stays low, the multiplier stages set the rate of one beat per clock
// reset clears the valid bits only; the receiver cannot stall, so nothing holds
`default_nettype none

module quaternion_arith_unit (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             start,
	output logic                                  busy,
	input  wire logic [1:0]                       mode,
	input  wire logic signed [qau_pkg::DATA_W-1:0] a_x,
	input  wire logic signed [qau_pkg::DATA_W-1:0] a_y,
	input  wire logic signed [qau_pkg::DATA_W-1:0] a_z,
	input  wire logic signed [qau_pkg::DATA_W-1:0] a_w,
	input  wire logic signed [qau_pkg::DATA_W-1:0] b_x,
	input  wire logic signed [qau_pkg::DATA_W-1:0] b_y,
	input  wire logic signed [qau_pkg::DATA_W-1:0] b_z,
	input  wire logic signed [qau_pkg::DATA_W-1:0] b_w,
	output logic                                  done,
	output logic signed [qau_pkg::DATA_W-1:0]      r_x,
	output logic signed [qau_pkg::DATA_W-1:0]      r_y,
	output logic signed [qau_pkg::DATA_W-1:0]      r_z,
	output logic signed [qau_pkg::DATA_W-1:0]      r_w,
	output logic                                  saturated
);

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	qau_pkg::mode_t mode_s1, mode_s2, mode_s3, mode_s4, mode_s5, mode_s6;

	logic signed [qau_pkg::DATA_W-1:0] bv_s1 [qau_pkg::N_V];
	logic signed [qau_pkg::DATA_W-1:0] bv_s2 [qau_pkg::N_V];
	logic signed [qau_pkg::DATA_W-1:0] bv_s3 [qau_pkg::N_V];

	logic signed [qau_pkg::ACC_W-1:0]  sum_s2 [qau_pkg::N_SUM];
	qau_pkg::rnd_t                     rnd_s3 [qau_pkg::N_SUM];
	logic signed [qau_pkg::DATA_W-1:0] mat_s3 [qau_pkg::N_M];
	logic signed [qau_pkg::ACC_W-1:0]  rsum_s5 [qau_pkg::N_V];
	qau_pkg::rnd_t                     rot_s6 [qau_pkg::N_V];

	logic signed [qau_pkg::DATA_W-1:0] qr_s4 [qau_pkg::N_Q];
	logic signed [qau_pkg::DATA_W-1:0] qr_s5 [qau_pkg::N_Q];
	logic signed [qau_pkg::DATA_W-1:0] qr_s6 [qau_pkg::N_Q];
	logic qsat_s4, qsat_s5, qsat_s6;
	logic msat_s4, msat_s5, msat_s6;
	logic qsat_any, msat_any;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			v_s1 <= start && !busy;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		mode_s1 <= qau_pkg::mode_t'(mode);
		mode_s2 <= mode_s1;
		mode_s3 <= mode_s2;
		mode_s4 <= mode_s3;
		mode_s5 <= mode_s4;
		mode_s6 <= mode_s5;
		bv_s1   <= '{b_x, b_y, b_z};
		bv_s2   <= bv_s1;
		bv_s3   <= bv_s2;
	end

	qau_quat_stage u_quat (
		.clk     (clk),
		.mode_s1 (mode_s1),
		.a_x     (a_x),
		.a_y     (a_y),
		.a_z     (a_z),
		.a_w     (a_w),
		.b_x     (b_x),
		.b_y     (b_y),
		.b_z     (b_z),
		.b_w     (b_w),
		.sum_s2  (sum_s2)
	);

	for (genvar g = 0; g < qau_pkg::N_SUM; g++) begin : g_rnd1
		qau_round_lane u_lane (
			.clk (clk),
			.acc (sum_s2[g]),
			.res (rnd_s3[g])
		);
	end

	always_comb begin
		qsat_any = 1'b0;
		msat_any = 1'b0;
		for (int k = 0; k < qau_pkg::N_Q; k++) begin
			qsat_any = qsat_any | rnd_s3[k].sat;
		end
		for (int k = 0; k < qau_pkg::N_M; k++) begin
			mat_s3[k] = rnd_s3[qau_pkg::N_Q + k].val;
			msat_any  = msat_any | rnd_s3[qau_pkg::N_Q + k].sat;
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < qau_pkg::N_Q; k++) begin
			qr_s4[k] <= rnd_s3[k].val;
		end
		qsat_s4 <= qsat_any;
		msat_s4 <= msat_any;
		qr_s5   <= qr_s4;
		qsat_s5 <= qsat_s4;
		msat_s5 <= msat_s4;
		qr_s6   <= qr_s5;
		qsat_s6 <= qsat_s5;
		msat_s6 <= msat_s5;
	end

	qau_rot_stage u_rot (
		.clk     (clk),
		.mat     (mat_s3),
		.vec     (bv_s3),
		.rsum_s5 (rsum_s5)
	);

	for (genvar g = 0; g < qau_pkg::N_V; g++) begin : g_rnd2
		qau_round_lane u_lane (
			.clk (clk),
			.acc (rsum_s5[g]),
			.res (rot_s6[g])
		);
	end

	assign done = v_s6;

	always_comb begin
		unique case (mode_s6)
			qau_pkg::MODE_QMUL, qau_pkg::MODE_RATE: begin
				r_x       = qr_s6[0];
				r_y       = qr_s6[1];
				r_z       = qr_s6[2];
				r_w       = qr_s6[3];
				saturated = qsat_s6;
			end
			qau_pkg::MODE_ROT: begin
				r_x       = rot_s6[0].val;
				r_y       = rot_s6[1].val;
				r_z       = rot_s6[2].val;
				r_w       = '0;
				saturated = msat_s6 | rot_s6[0].sat | rot_s6[1].sat | rot_s6[2].sat;
			end
			qau_pkg::MODE_NONE: begin
				r_x       = '0;
				r_y       = '0;
				r_z       = '0;
				r_w       = '0;
				saturated = 1'b0;
			end
		endcase
	end

endmodule

`default_nettype wire

>>> hdl/qau_checker.sv
// qau_checker: port-level checks of the quaternion unit, bound to the top level
// depends on qau_pkg and quaternion_arith_unit
`default_nettype none

module qau_checker (
	input wire logic                             clk,
	input wire logic                             arst_n,
	input wire logic                             start,
	input wire logic                             busy,
	input wire logic [1:0]                       mode,
	input wire logic                             done,
	input wire logic signed [qau_pkg::DATA_W-1:0] r_x,
	input wire logic signed [qau_pkg::DATA_W-1:0] r_w,
	input wire logic                             saturated
);

	localparam logic [1:0] M_ROT  = qau_pkg::MODE_ROT;
	localparam logic [1:0] M_NONE = qau_pkg::MODE_NONE;

	a_beat_done: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##6 done)
		else $error("accepted beat gave no result");

	a_done_beat: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 6))
		else $error("result without an accepted beat");

	a_rot_w: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && mode == M_ROT) |-> ##6 (done && r_w == '0))
		else $error("rotate result has nonzero scalar");

	a_none: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && mode == M_NONE) |-> ##6 (!saturated && r_x == '0 && r_w == '0))
		else $error("unused mode gave nonzero result");

endmodule

bind quaternion_arith_unit qau_checker u_qau_checker (.*);

`default_nettype wire
